// File: hw/rtl/riscv_subset_single_cycle_core_defines.svh
// assertion macros for the riscv subset core
`ifndef RISCV_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH
`define RISCV_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RSSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define RSSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rssc_pkg.sv
// constants and types for the riscv subset core
`default_nettype none

package rssc_pkg;

  // data memory depth in words, a power of two
  localparam int unsigned DMEM_WORDS = 1024;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 120;

  // opcodes
  localparam logic [6:0] OP_R   = 7'b0110011;
  localparam logic [6:0] OP_I   = 7'b0010011;
  localparam logic [6:0] OP_LD  = 7'b0000011;
  localparam logic [6:0] OP_ST  = 7'b0100011;
  localparam logic [6:0] OP_BR  = 7'b1100011;
  localparam logic [6:0] OP_JMP = 7'b1101111;

  // funct7 / funct3 codes
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_MUL  = 7'b1000000;
  localparam logic [6:0] F7_SUB  = 7'b0100000;
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_AND  = 3'b111;
  localparam logic [2:0] F3_OR   = 3'b110;

  typedef logic [DMEM_AW-1:0] dmem_addr_t;

  // one result word
  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_stored;
    logic [9:0]  mem_address;
    logic [31:0] mem_value;
    logic        branch_taken;
    logic        bad_instruction;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/riscv_subset_single_cycle_core.sv
// top level of the riscv subset core: decode, register file, data memory
`default_nettype none
`include "riscv_subset_single_cycle_core_defines.svh"

// Executes one instruction of a small RV32 subset per input word (add, sub, and,
// or, mul, addi, andi, ori, lw, sw, beq, absolute jump) or preloads one data
// memory word. Every input word gives exactly one result word. In the accept
// cycle the register file (two synchronous read ports) and the data memory
// (one synchronous read port) are read into the stage 1 registers; when the
// stage 1 word fires, the operands come out of the memory registers, the alu
// or multiplier works, and the register file, data memory and program counter
// are written while the result goes to the output register. A write made as
// stage 1 fires is forwarded to a read of the same entry issued in the same
// cycle, so a new word is taken every cycle and the sustained rate is one
// word per cycle while the output side takes results. After reset the data
// memory is swept to zero, one word a cycle, over all DMEM_WORDS (1024) words;
// s_axis_tready stays low during that sweep. Register x0 reads zero and is
// never written; the other registers read zero until first written.
module riscv_subset_single_cycle_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] instruction, [41:32] preload_address, [73:42] preload_value, rest zero
  input  wire logic [rssc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] action: 0 execute, 1 preload
  input  wire logic                           s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [31:0] next_pc, [32] reg_write, [37:33] reg_index, [69:38] reg_value,
  // [70] mem_stored, [80:71] mem_address, [112:81] mem_value,
  // [113] branch_taken, [114] bad_instruction, rest zero
  output logic [rssc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import rssc_pkg::*;

  // ---------------------------------------------------------------------------
  // storage
  // ---------------------------------------------------------------------------
  logic [31:0] rf_mem [32];
  logic [31:0] dm_mem [DMEM_WORDS];
  logic [31:0] rf_vld_q;          // register holds a written value

  // data memory clearing sweep after reset
  logic        clr_q;
  dmem_addr_t  clr_cnt_q;

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  logic    s1_vld_q;
  logic    out_vld_q;
  result_t out_q;
  logic    s_fire;
  logic    s1_fire;

  assign s1_fire       = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !clr_q && (!s1_vld_q || s1_fire);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // input fields and load address for the read issued at accept
  // ---------------------------------------------------------------------------
  logic [31:0] in_ins;
  logic [9:0]  in_paddr;
  logic [31:0] in_pval;
  logic [4:0]  in_rs1;
  logic [4:0]  in_rs2;
  logic [31:0] in_ld_sum;
  dmem_addr_t  in_ld_addr;

  assign in_ins     = s_axis_tdata[31:0];
  assign in_paddr   = s_axis_tdata[41:32];
  assign in_pval    = s_axis_tdata[73:42];
  assign in_rs1     = in_ins[19:15];
  assign in_rs2     = in_ins[24:20];
  // load address is the rs1 field number plus the i immediate
  assign in_ld_sum  = 32'(in_rs1) + {{20{in_ins[31]}}, in_ins[31:20]};
  assign in_ld_addr = in_ld_sum[DMEM_AW-1:0];

  // ---------------------------------------------------------------------------
  // stage 1 registers: item plus read data and forwarding marks
  // ---------------------------------------------------------------------------
  logic        s1_action_q;
  logic [31:0] s1_ins_q;
  logic [9:0]  s1_paddr_q;
  logic [31:0] s1_pval_q;
  logic [31:0] rd1_q, rd2_q;      // register file read data
  logic        rv1_q, rv2_q;      // register was valid at read
  logic        fa_q, fb_q;        // forward the write of the previous word
  logic [31:0] rf_fwd_q;
  logic [31:0] dm_rd_q;
  logic        fm_q;
  logic [31:0] dm_fwd_q;

  // stage 1 write-back, produced combinationally below
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        dm_we;
  dmem_addr_t  dm_wa;
  logic [31:0] dm_wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_fire) begin
      s1_vld_q <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_action_q <= s_axis_tuser;
      s1_ins_q    <= in_ins;
      s1_paddr_q  <= in_paddr;
      s1_pval_q   <= in_pval;
      rv1_q       <= rf_vld_q[in_rs1];
      rv2_q       <= rf_vld_q[in_rs2];
      // a write in this same cycle wins over the stored copy
      fa_q        <= s1_fire && rf_we && (rf_wa == in_rs1);
      fb_q        <= s1_fire && rf_we && (rf_wa == in_rs2);
      rf_fwd_q    <= rf_wd;
      fm_q        <= s1_fire && dm_we && (dm_wa == in_ld_addr);
      dm_fwd_q    <= dm_wd;
    end
  end

  // register file: two registered reads, one write
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      rd1_q <= rf_mem[in_rs1];
      rd2_q <= rf_mem[in_rs2];
    end
    if (s1_fire && rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (s1_fire && rf_we) begin
      rf_vld_q[rf_wa] <= 1'b1;
    end
  end

  // data memory: one registered read, one write shared with the clearing sweep
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      dm_rd_q <= dm_mem[in_ld_addr];
    end
    if (clr_q) begin
      dm_mem[clr_cnt_q] <= '0;
    end else if (s1_fire && dm_we) begin
      dm_mem[dm_wa] <= dm_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == DMEM_AW'(DMEM_WORDS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 execute
  // ---------------------------------------------------------------------------
  logic [31:0] pc_q;
  logic [31:0] op_a, op_b, ld_val;
  result_t     res;

  assign op_a   = fa_q ? rf_fwd_q : (rv1_q ? rd1_q : '0);
  assign op_b   = fb_q ? rf_fwd_q : (rv2_q ? rd2_q : '0);
  assign ld_val = fm_q ? dm_fwd_q : dm_rd_q;

  always_comb begin
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1f;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_j;
    logic [31:0] sum_ld, sum_st;
    logic [31:0] prod;
    logic [31:0] npc;
    logic        wr, mw, taken, bad;
    logic [31:0] wval, mval;
    dmem_addr_t  maddr;

    opc   = s1_ins_q[6:0];
    rd    = s1_ins_q[11:7];
    f3    = s1_ins_q[14:12];
    rs1f  = s1_ins_q[19:15];
    f7    = s1_ins_q[31:25];
    imm_i = {{20{s1_ins_q[31]}}, s1_ins_q[31:20]};
    imm_s = {{20{s1_ins_q[31]}}, s1_ins_q[31:25], s1_ins_q[11:7]};
    imm_b = {{19{s1_ins_q[31]}}, s1_ins_q[31], s1_ins_q[7], s1_ins_q[30:25],
             s1_ins_q[11:8], 1'b0};
    imm_j = {11'b0, s1_ins_q[31], s1_ins_q[19:12], s1_ins_q[20],
             s1_ins_q[30:21], 1'b0};
    sum_ld = 32'(rs1f) + imm_i;
    sum_st = 32'(rs1f) + imm_s;
    prod   = op_a * op_b;

    npc   = pc_q + 32'd4;
    wr    = 1'b0;
    wval  = '0;
    mw    = 1'b0;
    maddr = '0;
    mval  = '0;
    taken = 1'b0;
    bad   = 1'b0;

    if (s1_action_q) begin
      // preload: memory word only, pc holds
      maddr = DMEM_AW'(32'(s1_paddr_q));
      mval  = s1_pval_q;
      mw    = 1'b1;
      npc   = pc_q;
    end else begin
      unique case (opc)
        OP_R: begin
          wr = 1'b1;
          if (f7 == F7_BASE && f3 == F3_ADD) begin
            wval = op_a + op_b;
          end else if (f7 == F7_SUB && f3 == F3_ADD) begin
            wval = op_a - op_b;
          end else if (f7 == F7_BASE && f3 == F3_AND) begin
            wval = op_a & op_b;
          end else if (f7 == F7_BASE && f3 == F3_OR) begin
            wval = op_a | op_b;
          end else if (f7 == F7_MUL && f3 == F3_ADD) begin
            wval = prod;
          end else begin
            wr  = 1'b0;
            bad = 1'b1;
          end
        end
        OP_I: begin
          wr = 1'b1;
          if (f3 == F3_ADD) begin
            wval = op_a + imm_i;
          end else if (f3 == F3_AND) begin
            wval = op_a & imm_i;
          end else if (f3 == F3_OR) begin
            wval = op_a | imm_i;
          end else begin
            wr  = 1'b0;
            bad = 1'b1;
          end
        end
        OP_LD: begin
          maddr = sum_ld[DMEM_AW-1:0];
          mval  = ld_val;
          wr    = 1'b1;
          wval  = ld_val;
        end
        OP_ST: begin
          maddr = sum_st[DMEM_AW-1:0];
          mval  = op_b;
          mw    = 1'b1;
        end
        OP_BR: begin
          if (op_a == op_b) begin
            taken = 1'b1;
            npc   = pc_q + imm_b;
          end
        end
        OP_JMP: begin
          taken = 1'b1;
          npc   = imm_j;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end

    // x0 is never written and reports nothing
    if (!(wr && rd != 5'd0)) begin
      wr   = 1'b0;
      rd   = 5'd0;
      wval = '0;
    end

    rf_we = wr;
    rf_wa = rd;
    rf_wd = wval;
    dm_we = mw;
    dm_wa = maddr;
    dm_wd = mval;

    res.next_pc         = npc;
    res.reg_write       = wr;
    res.reg_index       = rd;
    res.reg_value       = wval;
    res.mem_stored      = mw;
    res.mem_address     = 10'(32'(maddr));
    res.mem_value       = mval;
    res.branch_taken    = taken;
    res.bad_instruction = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s1_fire) begin
      pc_q <= res.next_pc;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0,
                          out_q.bad_instruction,
                          out_q.branch_taken,
                          out_q.mem_value,
                          out_q.mem_address,
                          out_q.mem_stored,
                          out_q.reg_value,
                          out_q.reg_index,
                          out_q.reg_write,
                          out_q.next_pc};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `RSSC_ASSERT_NOW(a_no_accept_in_clear, clr_q, !s_fire, "word accepted during memory clear")
  `RSSC_ASSERT_NEXT(a_s1_holds, s1_vld_q && !s1_fire, s1_vld_q, "stalled stage 1 word lost")
  `RSSC_ASSERT_NEXT(a_fire_to_out, s1_fire, out_vld_q, "executed word missing at output")
  `RSSC_ASSERT_NOW(a_x0_unwritten, 1'b1, !rf_vld_q[0], "register x0 was written")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench for the riscv subset core: shadow core model, random programs, stream checks

module tb;
  import rssc_pkg::*;

  // action codes carried on s_axis_tuser
  localparam logic ACT_EXEC    = 1'b0;
  localparam logic ACT_PRELOAD = 1'b1;

  // encodings outside the subset, used to provoke the bad instruction flag
  localparam logic [6:0] OP_LUI        = 7'b0110111;
  localparam logic [6:0] F7_MULDIV_STD = 7'b0000001;
  localparam logic [2:0] F3_SLL        = 3'b001;
  // funct3 of lw, sw and beq in the standard encoding (ignored by the core)
  localparam logic [2:0] F3_WORD = 3'b010;
  localparam logic [2:0] F3_BEQ  = 3'b000;

  // idle cycles without any handshake before the run is declared hung;
  // covers the memory sweep after reset with a wide margin
  localparam int unsigned IDLE_LIMIT = 8000;
  localparam int unsigned N_RANDOM   = 950;
  localparam int unsigned MAX_PRINTS = 50;

  typedef enum int unsigned {
    K_ADD, K_SUB, K_AND, K_OR, K_MUL, K_ADDI, K_ANDI, K_ORI, K_LW, K_SW, K_BEQ, K_JMP
  } insn_kind_e;

  // one result word, split into its fields
  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_stored;
    logic [9:0]  mem_address;
    logic [31:0] mem_value;
    logic        branch_taken;
    logic        bad_instruction;
  } outcome_t;

  // shadow copy of the core: architectural state plus the results still owed
  class core_shadow;
    logic [31:0] pc;
    logic [31:0] regs [32];
    logic [31:0] dmem [DMEM_WORDS];
    outcome_t    owed_results [$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      pc = '0;
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    task flag_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
    endtask

    // execute one accepted input word and queue the result it owes
    function void execute_word(logic act, logic [31:0] ins, logic [9:0] paddr,
                               logic [31:0] pval);
      logic [6:0]  opc, f7;
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, addr_sum, wval;
      logic        wr;
      outcome_t    r;
      opc = ins[6:0];
      rd  = ins[11:7];
      f3  = ins[14:12];
      rs1 = ins[19:15];
      rs2 = ins[24:20];
      f7  = ins[31:25];
      a = regs[rs1];
      b = regs[rs2];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      imm_j = {11'b0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      r = '0;
      r.next_pc = pc + 32'd4;
      wr = 1'b0;
      wval = '0;
      if (act == ACT_PRELOAD) begin
        r.mem_stored = 1'b1;
        r.mem_address = paddr;
        r.mem_value = pval;
        dmem[paddr] = pval;
        r.next_pc = pc;
      end else begin
        case (opc)
          OP_R: begin
            wr = 1'b1;
            if (f7 == F7_BASE && f3 == F3_ADD) wval = a + b;
            else if (f7 == F7_SUB && f3 == F3_ADD) wval = a - b;
            else if (f7 == F7_BASE && f3 == F3_AND) wval = a & b;
            else if (f7 == F7_BASE && f3 == F3_OR) wval = a | b;
            else if (f7 == F7_MUL && f3 == F3_ADD) wval = a * b;
            else begin
              wr = 1'b0;
              r.bad_instruction = 1'b1;
            end
          end
          OP_I: begin
            wr = 1'b1;
            if (f3 == F3_ADD) wval = a + imm_i;
            else if (f3 == F3_AND) wval = a & imm_i;
            else if (f3 == F3_OR) wval = a | imm_i;
            else begin
              wr = 1'b0;
              r.bad_instruction = 1'b1;
            end
          end
          OP_LD: begin
            // the address uses the rs1 field number, not the register contents
            addr_sum = {27'b0, rs1} + imm_i;
            r.mem_address = addr_sum[DMEM_AW-1:0];
            r.mem_value = dmem[r.mem_address];
            wr = 1'b1;
            wval = r.mem_value;
          end
          OP_ST: begin
            addr_sum = {27'b0, rs1} + imm_s;
            r.mem_address = addr_sum[DMEM_AW-1:0];
            r.mem_value = b;
            r.mem_stored = 1'b1;
            dmem[r.mem_address] = b;
          end
          OP_BR: begin
            if (a == b) begin
              r.branch_taken = 1'b1;
              r.next_pc = pc + imm_b;
            end
          end
          OP_JMP: begin
            r.branch_taken = 1'b1;
            r.next_pc = imm_j;
          end
          default: r.bad_instruction = 1'b1;
        endcase
      end
      // x0 is never written and a skipped write reports zeros
      if (wr && rd != 5'd0) begin
        regs[rd] = wval;
        r.reg_write = 1'b1;
        r.reg_index = rd;
        r.reg_value = wval;
      end
      pc = r.next_pc;
      owed_results.push_back(r);
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      outcome_t got, want;
      got.next_pc         = d[31:0];
      got.reg_write       = d[32];
      got.reg_index       = d[37:33];
      got.reg_value       = d[69:38];
      got.mem_stored      = d[70];
      got.mem_address     = d[80:71];
      got.mem_value       = d[112:81];
      got.branch_taken    = d[113];
      got.bad_instruction = d[114];
      results_seen++;
      if (owed_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, next_pc %h", got.next_pc));
      end else begin
        want = owed_results.pop_front();
        compare_field("next_pc", got.next_pc, want.next_pc);
        compare_field("reg_write", 32'(got.reg_write), 32'(want.reg_write));
        compare_field("reg_index", 32'(got.reg_index), 32'(want.reg_index));
        compare_field("reg_value", got.reg_value, want.reg_value);
        compare_field("mem_stored", 32'(got.mem_stored), 32'(want.mem_stored));
        compare_field("mem_address", 32'(got.mem_address), 32'(want.mem_address));
        compare_field("mem_value", got.mem_value, want.mem_value);
        compare_field("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
        compare_field("bad_instruction", 32'(got.bad_instruction),
                      32'(want.bad_instruction));
      end
    endtask
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  core_shadow  shadow;
  int unsigned burst_left;
  int unsigned idle_cycles = 0;
  int unsigned rcv_cycle   = 0;
  logic [15:0] ready_pattern = 16'hffff;

  riscv_subset_single_cycle_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // instruction encoders, one per format
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OP_R};
  endfunction

  function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_ST};
  endfunction

  function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BR};
  endfunction

  function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JMP};
  endfunction

  // mostly the low registers, so results feed later instructions
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  // one well-formed instruction of the subset with random content
  function automatic logic [31:0] rand_insn();
    insn_kind_e  kind;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3_any;
    logic [31:0] imm, mem_off;
    kind = insn_kind_e'($urandom_range(0, int'(K_JMP)));
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    f3_any = 3'($urandom_range(0, 7));
    imm = $urandom();
    // memory offsets mostly small so loads meet earlier stores and preloads
    mem_off = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 40) - 8 : imm;
    case (kind)
      K_ADD:   return enc_r(F7_BASE, F3_ADD, rd, rs1, rs2);
      K_SUB:   return enc_r(F7_SUB, F3_ADD, rd, rs1, rs2);
      K_AND:   return enc_r(F7_BASE, F3_AND, rd, rs1, rs2);
      K_OR:    return enc_r(F7_BASE, F3_OR, rd, rs1, rs2);
      K_MUL:   return enc_r(F7_MUL, F3_ADD, rd, rs1, rs2);
      K_ADDI:  return enc_i(OP_I, F3_ADD, rd, rs1, imm[11:0]);
      K_ANDI:  return enc_i(OP_I, F3_AND, rd, rs1, imm[11:0]);
      K_ORI:   return enc_i(OP_I, F3_OR, rd, rs1, imm[11:0]);
      K_LW:    return enc_i(OP_LD, f3_any, rd, rs1, mem_off[11:0]);
      K_SW:    return enc_s(f3_any, rs1, rs2, mem_off[11:0]);
      // half the compares use the same register so the branch is taken
      K_BEQ:   return enc_b(f3_any, rs1, $urandom_range(0, 1) ? rs1 : rs2, imm[12:0]);
      default: return enc_j(rd, imm[20:0]);
    endcase
  endfunction

  // send one word; called just after a falling edge, returns after one
  task automatic send_word(logic act, logic [31:0] ins, logic [9:0] paddr, logic [31:0] pval);
    int unsigned gap;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'b0, pval, paddr, ins};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.execute_word(act, ins, paddr, pval);
    @(negedge clk_i);
    // bursts of random length, sometimes back to back, with random gaps
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // execute item; the preload fields carry junk that must be ignored
  task automatic exec_insn(logic [31:0] ins);
    send_word(ACT_EXEC, ins, 10'($urandom()), $urandom());
  endtask

  // preload item; the instruction field carries junk that must be ignored
  task automatic preload(logic [9:0] addr, logic [31:0] value);
    send_word(ACT_PRELOAD, $urandom(), addr, value);
  endtask

  // result side stalls on a repeating random ready pattern that is itself redrawn periodically
  always @(negedge clk_i) begin
    if (rcv_cycle % 256 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hffff;
        1:       ready_pattern = 16'($urandom() & $urandom()) | 16'h0001;
        default: ready_pattern = 16'($urandom()) | 16'h0001;
      endcase
    end
    m_axis_tready <= ready_pattern[rcv_cycle % 16];
    rcv_cycle++;
  end

  // every accepted result is compared against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) shadow.check_result(m_axis_tdata);
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    shadow = new();
    burst_left = $urandom_range(1, 12);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extreme values, every operation, wrap cases and bad encodings
    preload(10'd0, 32'h7fff_ffff);
    preload(10'd1023, 32'h8000_0000);
    exec_insn(enc_i(OP_LD, F3_WORD, 5'd1, 5'd0, 12'h000));
    // negative offset from the x0 field wraps to the last word
    exec_insn(enc_i(OP_LD, F3_WORD, 5'd2, 5'd0, 12'hfff));
    exec_insn(enc_r(F7_BASE, F3_ADD, 5'd3, 5'd1, 5'd1));
    exec_insn(enc_r(F7_SUB, F3_ADD, 5'd4, 5'd2, 5'd1));
    exec_insn(enc_r(F7_BASE, F3_AND, 5'd5, 5'd1, 5'd2));
    exec_insn(enc_r(F7_BASE, F3_OR, 5'd6, 5'd1, 5'd2));
    exec_insn(enc_r(F7_MUL, F3_ADD, 5'd7, 5'd1, 5'd1));
    exec_insn(enc_i(OP_I, F3_ADD, 5'd8, 5'd1, 12'h001));
    exec_insn(enc_i(OP_I, F3_AND, 5'd9, 5'd6, 12'h800));
    exec_insn(enc_i(OP_I, F3_OR, 5'd10, 5'd0, 12'h7ff));
    // destination x0 writes nothing
    exec_insn(enc_r(F7_BASE, F3_ADD, 5'd0, 5'd1, 5'd1));
    // field 31 plus 2047 wraps past the memory end
    exec_insn(enc_s(F3_WORD, 5'd31, 5'd1, 12'h7ff));
    exec_insn(enc_i(OP_LD, 3'($urandom_range(0, 7)), 5'd11, 5'd31, 12'h7ff));
    // most negative taken branch wraps the pc, then a not-taken compare
    exec_insn(enc_b(F3_BEQ, 5'd1, 5'd1, 13'h1000));
    exec_insn(enc_b(F3_BEQ, 5'd1, 5'd2, 13'h0ffe));
    // jumps to the top and bottom of the range, no link even with rd set
    exec_insn(enc_j(5'd5, 21'h1ffffe));
    exec_insn(enc_j(5'd0, 21'h000000));
    // unmatched function codes and unknown opcodes
    exec_insn(enc_r(F7_MULDIV_STD, F3_ADD, 5'd12, 5'd1, 5'd2));
    exec_insn(enc_r(F7_BASE, F3_SLL, 5'd12, 5'd1, 5'd2));
    exec_insn(enc_r(F7_SUB, F3_AND, 5'd12, 5'd1, 5'd2));
    exec_insn(enc_i(OP_I, F3_SLL, 5'd13, 5'd1, 12'h001));
    exec_insn({25'h0abcd12, OP_LUI});
    exec_insn(32'hffff_ffff);
    exec_insn(32'h0000_0000);

    // random program: mostly valid instructions, some preloads, some noise
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        preload(($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                            : 10'($urandom_range(0, 63)),
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 15));
      end else if (sel < 25) begin
        case ($urandom_range(0, 2))
          0:       exec_insn($urandom());
          1:       exec_insn(enc_r(7'($urandom()), 3'($urandom()), pick_reg(), pick_reg(),
                                   pick_reg()));
          default: exec_insn(enc_i(OP_I, 3'($urandom_range(1, 5)), pick_reg(), pick_reg(),
                                   12'($urandom())));
        endcase
      end else begin
        exec_insn(rand_insn());
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give a stray extra result time to show up
    while (shadow.owed_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
